>>> rtl/bfa_pkg.sv
// bfa_pkg: shared constants, transfer types and item kind codes of the frame allocator
package bfa_pkg;

    // frame geometry
    localparam int FRAME_COUNT = 32768;
    localparam int FRAME_BYTES = 4096;
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);

    // bitmap storage: one 32-bit word holds the used bits of 32 frames
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    // frame numbers derived from a 32-bit byte address
    localparam int ADDR_FRAME_W = 32 - FRAME_SHIFT;
    localparam int FIDX_W       = $clog2(FRAME_COUNT + 1);
    localparam int NUM_W        = ((ADDR_FRAME_W > FIDX_W) ? ADDR_FRAME_W : FIDX_W) + 1;

    localparam logic [31:0] LOW_MEM_FLOOR = 32'h0010_0000;
    localparam logic [31:0] IMAGE_LIMIT_RESET = 32'h0010_0000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // item kinds
    localparam logic [1:0] KIND_REGION = 2'd0;
    localparam logic [1:0] KIND_ALLOC  = 2'd1;
    localparam logic [1:0] KIND_FREE   = 2'd2;

    localparam logic [31:0] TYPE_USABLE = 32'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] region_length;
        logic [31:0] region_type;
        logic        above_4g;
    } bfa_in_t;

    typedef struct packed {
        logic [31:0] frame_address;
        logic        granted;
        logic [15:0] free_count;
        logic [15:0] total_count;
    } bfa_out_t;

endpackage

>>> rtl/bfa_ram.sv
// bfa_ram: generic single write port, single read port ram with registered read data
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bitmap_frame_allocator.sv
// bitmap_frame_allocator: top level of the bitmap page-frame allocator
//
// Input transfers on s_valid/s_ready carry one item: a memory-map region to
// release, a request for the lowest free frame, or a frame to give back.
// Every item yields exactly one result transfer on m_valid/m_ready with the
// granted frame address, a grant flag and the free and total frame counts.
// The kernel end address is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while no item is in progress, which the block does not enforce.
// The used bits sit in a 1024 x 32 ram behind one read-modify-write unit
// driven by a small sequencer; one item is worked on at a time.
// A free reads its word and writes it back if the frame was used (a frame beyond
// the map goes straight to the result); alloc streams the map word by word until
// one has a clear bit; a region reads and writes back each bitmap word it
// touches; kind 3 and ignored regions go straight to the result.
// After aresetn the block sweeps the ram, one word a cycle, setting every
// frame used: s_ready stays low until the sweep ends; counters read zero.
// A result waits in an output register; the next item is accepted while it
// waits, and its own result is held back until the receiver takes the first.
module bitmap_frame_allocator (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  bfa_pkg::bfa_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bfa_pkg::bfa_out_t m_data
);

    localparam int FS   = bfa_pkg::FRAME_SHIFT;
    localparam int AFW  = bfa_pkg::ADDR_FRAME_W;
    localparam int NW   = bfa_pkg::NUM_W;
    localparam int AW   = bfa_pkg::WORD_AW;
    localparam int BW   = bfa_pkg::BIT_W;
    localparam int WB   = bfa_pkg::WORD_BITS;
    localparam logic [AW-1:0]  LAST_WORD  = AW'(bfa_pkg::MAP_WORDS - 1);
    localparam logic [AFW-1:0] TOP_FRAME  = {AFW{1'b1}};
    localparam logic [NW-1:0]  FRAME_LIM  = NW'(bfa_pkg::FRAME_COUNT);
    localparam logic [31:0]    FRAME_MASK = 32'(bfa_pkg::FRAME_BYTES - 1);
    localparam logic [WB-1:0]  ALL_USED   = {WB{1'b1}};
    localparam logic [BW-1:0]  TOP_BIT    = BW'(WB - 1);

    typedef enum logic [10:0] {
        ST_CLEAR     = 11'b000_0000_0001,
        ST_IDLE      = 11'b000_0000_0010,
        ST_RGN_PREP  = 11'b000_0000_0100,
        ST_RGN_SPAN  = 11'b000_0000_1000,
        ST_RGN_RD    = 11'b000_0001_0000,
        ST_RGN_WR    = 11'b000_0010_0000,
        ST_ALLOC     = 11'b000_0100_0000,
        ST_FREE_RD   = 11'b000_1000_0000,
        ST_FREE_WR   = 11'b001_0000_0000,
        ST_DONE      = 11'b010_0000_0000,
        ST_SPARE     = 11'b100_0000_0000
    } state_t;

    // saturating counter add
    function automatic logic [15:0] sat_add(input logic [15:0] c, input logic [BW:0] n);
        logic [16:0] sum;
        sum = {1'b0, c} + 17'(n);
        return (sum > {1'b0, bfa_pkg::COUNT_MAX}) ? bfa_pkg::COUNT_MAX : sum[15:0];
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     word_reg, word_next;
    logic [AW-1:0]     data_word_reg, data_word_next;
    logic              data_ok_reg, data_ok_next;
    logic [AW-1:0]     last_word_reg, last_word_next;
    logic [BW-1:0]     last_bit_reg, last_bit_next;
    logic [BW-1:0]     lo_reg, lo_next;
    logic [BW-1:0]     bit_reg, bit_next;
    logic [AFW-1:0]    f0_reg, f0_next;
    logic [AFW-1:0]    e_reg, e_next;
    bfa_pkg::bfa_in_t  in_reg, in_next;
    logic [15:0]       free_reg, free_next;
    logic [15:0]       total_reg, total_next;
    logic [31:0]       res_faddr_reg, res_faddr_next;
    logic              res_granted_reg, res_granted_next;
    logic              m_valid_reg, m_valid_next;
    bfa_pkg::bfa_out_t m_data_reg, m_data_next;
    logic [31:0]       kend_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WB-1:0]     ram_wdata;
    logic [WB-1:0]     ram_rdata;

    // combinational helpers
    logic [31:0]       addr_frame;
    logic [31:0]       start_a;
    logic [31:0]       start_rnd;
    logic [31:0]       end_a;
    logic [NW-1:0]     n_full;
    logic [NW-1:0]     n_cap;
    logic [NW-1:0]     n_last;
    logic [BW-1:0]     hi_bit;
    logic [WB-1:0]     span_mask;
    logic [BW:0]       span_count;
    logic [BW-1:0]     low_zero;
    logic [63:0]       alloc_addr;

    // bitmap store
    bfa_ram #(
        .WIDTH (WB),
        .DEPTH (bfa_pkg::MAP_WORDS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (word_reg),
        .rd_data (ram_rdata)
    );

    // lowest clear bit of the word just read
    always_comb begin
        low_zero = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (!ram_rdata[i]) begin
                low_zero = BW'(i);
            end
        end
    end

    assign alloc_addr = 64'({data_word_reg, low_zero}) << FS;

    // region span arithmetic
    always_comb begin
        start_a = in_reg.address;
        if (start_a < bfa_pkg::LOW_MEM_FLOOR) begin
            start_a = bfa_pkg::LOW_MEM_FLOOR;
        end
        if (start_a < kend_reg) begin
            start_a = kend_reg;
        end
        start_rnd = (start_a + FRAME_MASK) & ~FRAME_MASK;
        end_a     = in_reg.address + in_reg.region_length;

        // the top frame of the address space ends the walk once reached
        if (e_reg == TOP_FRAME || f0_reg == TOP_FRAME) begin
            n_full = NW'(TOP_FRAME) + NW'(1);
        end else begin
            n_full = NW'(e_reg);
        end
        n_cap  = (n_full > FRAME_LIM) ? FRAME_LIM : n_full;
        n_last = n_cap - NW'(1);
    end

    // bits of the current word inside the region
    always_comb begin
        hi_bit     = (word_reg == last_word_reg) ? last_bit_reg : TOP_BIT;
        span_mask  = (ALL_USED << lo_reg) & (ALL_USED >> (TOP_BIT - hi_bit));
        span_count = (BW + 1)'(hi_bit) - (BW + 1)'(lo_reg) + (BW + 1)'(1);
    end

    assign addr_frame = s_data.address >> FS;

    // sequencer
    always_comb begin
        state_next       = state_reg;
        word_next        = word_reg;
        data_word_next   = data_word_reg;
        data_ok_next     = data_ok_reg;
        last_word_next   = last_word_reg;
        last_bit_next    = last_bit_reg;
        lo_next          = lo_reg;
        bit_next         = bit_reg;
        f0_next          = f0_reg;
        e_next           = e_reg;
        in_next          = in_reg;
        free_next        = free_reg;
        total_next       = total_reg;
        res_faddr_next   = res_faddr_reg;
        res_granted_next = res_granted_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg;
        ram_we           = 1'b0;
        ram_waddr        = word_reg;
        ram_wdata        = ALL_USED;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // mark every frame used after reset
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (word_reg == LAST_WORD) begin
                    word_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    word_next = word_reg + AW'(1);
                end
            end

            // take one item
            ST_IDLE: begin
                if (s_valid) begin
                    in_next          = s_data;
                    res_faddr_next   = '0;
                    res_granted_next = 1'b0;
                    case (s_data.kind)
                        bfa_pkg::KIND_REGION: begin
                            if (s_data.region_type == bfa_pkg::TYPE_USABLE
                                && !s_data.above_4g) begin
                                state_next = ST_RGN_PREP;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        bfa_pkg::KIND_ALLOC: begin
                            word_next    = '0;
                            data_ok_next = 1'b0;
                            state_next   = ST_ALLOC;
                        end
                        bfa_pkg::KIND_FREE: begin
                            word_next = AW'(addr_frame >> BW);
                            bit_next  = addr_frame[BW-1:0];
                            if (addr_frame < 32'(bfa_pkg::FRAME_COUNT)) begin
                                state_next = ST_FREE_RD;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // clamp and align the region bounds
            ST_RGN_PREP: begin
                f0_next    = start_rnd[31:FS];
                e_next     = end_a[31:FS];
                state_next = ST_RGN_SPAN;
            end

            // turn the bounds into a word range
            ST_RGN_SPAN: begin
                if (NW'(f0_reg) >= n_cap) begin
                    state_next = ST_DONE;
                end else begin
                    word_next      = AW'(f0_reg >> BW);
                    lo_next        = f0_reg[BW-1:0];
                    last_word_next = AW'(n_last >> BW);
                    last_bit_next  = n_last[BW-1:0];
                    state_next     = ST_RGN_RD;
                end
            end

            // word read in flight
            ST_RGN_RD: begin
                state_next = ST_RGN_WR;
            end

            // clear the region bits of one word and count them
            ST_RGN_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata & ~span_mask;
                free_next  = sat_add(free_reg, span_count);
                total_next = sat_add(total_reg, span_count);
                lo_next    = '0;
                if (word_reg == last_word_reg) begin
                    state_next = ST_DONE;
                end else begin
                    word_next  = word_reg + AW'(1);
                    state_next = ST_RGN_RD;
                end
            end

            // streaming scan for the first word with a clear bit
            ST_ALLOC: begin
                if (data_ok_reg && ram_rdata != ALL_USED) begin
                    ram_we           = 1'b1;
                    ram_waddr        = data_word_reg;
                    ram_wdata        = ram_rdata | (WB'(1) << low_zero);
                    res_faddr_next   = alloc_addr[31:0];
                    res_granted_next = 1'b1;
                    if (free_reg != 16'd0) begin
                        free_next = free_reg - 16'd1;
                    end
                    state_next = ST_DONE;
                end else if (data_ok_reg && data_word_reg == LAST_WORD) begin
                    state_next = ST_DONE;
                end else begin
                    data_word_next = word_reg;
                    data_ok_next   = 1'b1;
                    if (word_reg != LAST_WORD) begin
                        word_next = word_reg + AW'(1);
                    end
                end
            end

            // word read in flight
            ST_FREE_RD: begin
                state_next = ST_FREE_WR;
            end

            // release the frame if it was used
            ST_FREE_WR: begin
                if (ram_rdata[bit_reg]) begin
                    ram_we           = 1'b1;
                    ram_wdata        = ram_rdata & ~(WB'(1) << bit_reg);
                    free_next        = sat_add(free_reg, (BW + 1)'(1));
                    res_granted_next = 1'b1;
                end
                state_next = ST_DONE;
            end

            // hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.frame_address = res_faddr_reg;
                    m_data_next.granted       = res_granted_reg;
                    m_data_next.free_count    = free_reg;
                    m_data_next.total_count   = total_reg;
                    m_valid_next              = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            word_reg    <= '0;
            data_ok_reg <= 1'b0;
            free_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            word_reg    <= word_next;
            data_ok_reg <= data_ok_next;
            free_reg    <= free_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // kernel end register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kend_reg <= bfa_pkg::IMAGE_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            kend_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        data_word_reg   <= data_word_next;
        last_word_reg   <= last_word_next;
        last_bit_reg    <= last_bit_next;
        lo_reg          <= lo_next;
        bit_reg         <= bit_next;
        f0_reg          <= f0_next;
        e_reg           <= e_next;
        in_reg          <= in_next;
        res_faddr_reg   <= res_faddr_next;
        res_granted_reg <= res_granted_next;
        m_data_reg      <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
